>>> src/tqts_pkg.sv
`default_nettype none

package tqts_pkg;

    localparam int DEFAULT_QUEUE_DEPTH = 16;
    localparam int THRESH_W            = 5;
    localparam logic [THRESH_W-1:0] THRESH_RESET = 5'd5;

    typedef enum logic [1:0] {
        KIND_ENQ_BUS = 2'd0,
        KIND_ENQ_SER = 2'd1,
        KIND_CPL_BUS = 2'd2,
        KIND_CPL_SER = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_FULL     = 2'd1,
        STATUS_SPURIOUS = 2'd2
    } t_status;

    localparam logic [1:0] XFER_READ       = 2'd0;
    localparam logic [1:0] XFER_WRITE      = 2'd1;
    localparam logic [1:0] XFER_WRITE_READ = 2'd2;
    localparam logic [1:0] XFER_UNUSED     = 2'd3;

    typedef struct packed {
        t_kind       kind;
        logic [2:0]  port;
        logic [6:0]  dev_addr;
        logic [7:0]  reg_addr;
        logic [1:0]  xfer_type;
        logic [15:0] length;
        logic [31:0] buf_addr;
    } t_in_item;

    typedef struct packed {
        logic        start_valid;
        logic        start_is_serial;
        logic [2:0]  start_port;
        logic [6:0]  start_dev_addr;
        logic [7:0]  start_reg_addr;
        logic [1:0]  start_type;
        logic [15:0] start_length;
        logic [31:0] start_buf_addr;
        logic        release_valid;
        logic [31:0] release_buf_addr;
        t_status     status;
    } t_out_item;

    // Queue entries as held in the descriptor stores.
    typedef struct packed {
        logic [2:0]  port;
        logic [6:0]  dev_addr;
        logic [7:0]  reg_addr;
        logic [1:0]  xfer_type;
        logic [15:0] length;
        logic [31:0] buf_addr;
    } t_bus_desc;

    typedef struct packed {
        logic [2:0]  port;
        logic [15:0] length;
        logic [31:0] buf_addr;
    } t_ser_desc;

endpackage

`default_nettype wire

>>> src/tqts_fifo.sv
`default_nettype none

// Circular descriptor queue with registered reads of the head entry and the
// entry behind it, so that a pop can hand out the new head in the same cycle.
module tqts_fifo #(
    parameter int DEPTH = tqts_pkg::DEFAULT_QUEUE_DEPTH,
    parameter int WIDTH = $bits(tqts_pkg::t_bus_desc)
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_push,
    input  wire logic                       i_pop,
    input  wire logic [WIDTH-1:0]           i_wdata,
    output logic      [$clog2(DEPTH+1)-1:0] o_count,
    output logic      [$clog2(DEPTH+1)-1:0] o_count_next,
    output logic      [WIDTH-1:0]           o_cur_head,
    output logic      [WIDTH-1:0]           o_new_head
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = AW + 1;

    logic [WIDTH-1:0] mem [DEPTH];

    logic [AW-1:0]    r_head;
    logic [CW-1:0]    r_count;
    logic [WIDTH-1:0] r_hd;
    logic [WIDTH-1:0] r_nx;

    logic [AW-1:0]    n_head;
    logic [AW-1:0]    n_head_plus;
    logic [CW-1:0]    n_count;
    logic [SW-1:0]    slot_sum;
    logic [AW-1:0]    waddr;

    function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] a);
        logic [AW-1:0] r;
        if (a == AW'(DEPTH - 1)) begin
            r = '0;
        end else begin
            r = a + 1'b1;
        end
        return r;
    endfunction

    always_comb begin
        slot_sum = SW'(r_head) + SW'(r_count);
        if (slot_sum >= SW'(DEPTH)) begin
            waddr = AW'(slot_sum - SW'(DEPTH));
        end else begin
            waddr = slot_sum[AW-1:0];
        end
        n_head      = i_pop ? wrap_inc(r_head) : r_head;
        n_head_plus = wrap_inc(n_head);
        if (i_push) begin
            n_count = r_count + 1'b1;
        end else if (i_pop) begin
            n_count = r_count - 1'b1;
        end else begin
            n_count = r_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_count <= n_count;
        end
    end

    // Write-first reads: an entry written this cycle is seen at once.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            mem[waddr] <= i_wdata;
        end
        r_hd <= (i_push && waddr == n_head)      ? i_wdata : mem[n_head];
        r_nx <= (i_push && waddr == n_head_plus) ? i_wdata : mem[n_head_plus];
    end

    always_comb begin
        if (i_pop) begin
            o_new_head = r_nx;
        end else if (i_push && r_count == '0) begin
            o_new_head = i_wdata;
        end else begin
            o_new_head = r_hd;
        end
    end

    assign o_count      = r_count;
    assign o_count_next = n_count;
    assign o_cur_head   = r_hd;

endmodule

`default_nettype wire

>>> src/two_queue_transfer_scheduler.sv
// Pipeline: an accepted request is held in the input register and moves on to the result
// register once the result register is empty or being drained.
// Throughput: one request per cycle while the result side is not backed up; the queue
// heads are read ahead from memory so the decision for each request is made combinationally.
// Reset: i_rst_n is synchronous and active low; it empties both queues, idles the
// engine and sets the threshold to 5. Queue storage itself is not cleared.
`default_nettype none

module two_queue_transfer_scheduler #(
    parameter int QUEUE_DEPTH = tqts_pkg::DEFAULT_QUEUE_DEPTH
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_in_valid,
    output logic                                    o_in_ready,
    input  wire tqts_pkg::t_in_item                 i_in,
    output logic                                    o_out_valid,
    input  wire logic                               i_out_ready,
    output tqts_pkg::t_out_item                     o_out,
    input  wire logic                               i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  wire logic [tqts_pkg::THRESH_W-1:0]      i_cfg_data
);

    localparam int CW   = $clog2(QUEUE_DEPTH + 1);
    localparam int CMPW = (CW > tqts_pkg::THRESH_W) ? CW : tqts_pkg::THRESH_W;
    localparam int BW   = $bits(tqts_pkg::t_bus_desc);
    localparam int SWD  = $bits(tqts_pkg::t_ser_desc);

    // Configuration: the threshold register can be written whenever the block
    // is out of reset.
    logic [tqts_pkg::THRESH_W-1:0] r_thresh;

    // Input register and result register with their valid flags.
    logic                 r_in_vld;
    tqts_pkg::t_in_item   r_in;
    logic                 r_out_vld;
    tqts_pkg::t_out_item  r_out;

    // Engine state.
    logic r_busy;
    logic r_busy_ser;
    logic n_busy;
    logic n_busy_ser;

    logic fire;

    logic                  bus_push;
    logic                  bus_pop;
    logic                  ser_push;
    logic                  ser_pop;
    tqts_pkg::t_bus_desc   bus_wdata;
    tqts_pkg::t_ser_desc   ser_wdata;
    logic [CW-1:0]         bus_count;
    logic [CW-1:0]         bus_count_next;
    logic [CW-1:0]         ser_count;
    logic [CW-1:0]         ser_count_next;
    tqts_pkg::t_bus_desc   bus_cur;
    tqts_pkg::t_bus_desc   bus_new;
    tqts_pkg::t_ser_desc   ser_cur;
    tqts_pkg::t_ser_desc   ser_new;
    logic                  spurious;
    logic                  pick_ser;
    logic                  do_start;
    tqts_pkg::t_out_item   res;

    assign o_cfg_ready = i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh <= tqts_pkg::THRESH_RESET;
        end else if (i_cfg_valid) begin
            r_thresh <= i_cfg_data;
        end
    end

    // The request in the input register moves on whenever the result register
    // is empty or being drained; the input side refills in the same cycle.
    // Nothing is taken while reset is held.
    assign fire       = r_in_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready = i_rst_n && (!r_in_vld || fire);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_in_ready) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in;
        end
    end

    // Descriptors as stored. A bus type code without meaning is kept as a read.
    always_comb begin
        bus_wdata.port      = r_in.port;
        bus_wdata.dev_addr  = r_in.dev_addr;
        bus_wdata.reg_addr  = r_in.reg_addr;
        bus_wdata.xfer_type = (r_in.xfer_type == tqts_pkg::XFER_UNUSED) ?
                              tqts_pkg::XFER_READ : r_in.xfer_type;
        bus_wdata.length    = r_in.length;
        bus_wdata.buf_addr  = r_in.buf_addr;
        ser_wdata.port      = r_in.port;
        ser_wdata.length    = r_in.length;
        ser_wdata.buf_addr  = r_in.buf_addr;
    end

    // Queue updates for the current request. Enqueues to a full queue are
    // dropped; a completion is honored only for the queue now in flight.
    always_comb begin
        spurious = !r_busy || (r_busy_ser != (r_in.kind == tqts_pkg::KIND_CPL_SER));
        bus_push = fire && r_in.kind == tqts_pkg::KIND_ENQ_BUS &&
                   bus_count != CW'(QUEUE_DEPTH);
        ser_push = fire && r_in.kind == tqts_pkg::KIND_ENQ_SER &&
                   ser_count != CW'(QUEUE_DEPTH);
        bus_pop  = fire && r_in.kind == tqts_pkg::KIND_CPL_BUS && !spurious;
        ser_pop  = fire && r_in.kind == tqts_pkg::KIND_CPL_SER && !spurious;
    end

    tqts_fifo #(
        .DEPTH (QUEUE_DEPTH),
        .WIDTH (BW)
    ) u_bus_q (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (bus_push),
        .i_pop        (bus_pop),
        .i_wdata      (bus_wdata),
        .o_count      (bus_count),
        .o_count_next (bus_count_next),
        .o_cur_head   (bus_cur),
        .o_new_head   (bus_new)
    );

    tqts_fifo #(
        .DEPTH (QUEUE_DEPTH),
        .WIDTH (SWD)
    ) u_ser_q (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (ser_push),
        .i_pop        (ser_pop),
        .i_wdata      (ser_wdata),
        .o_count      (ser_count),
        .o_count_next (ser_count_next),
        .o_cur_head   (ser_cur),
        .o_new_head   (ser_new)
    );

    // Start selection after the queue update. The serial queue jumps ahead
    // once its count, in-flight entry included, passes the threshold.
    always_comb begin
        n_busy     = r_busy && !(bus_pop || ser_pop);
        n_busy_ser = r_busy_ser;
        do_start   = 1'b0;
        pick_ser   = 1'b0;
        if (!n_busy) begin
            if (CMPW'(ser_count_next) > CMPW'(r_thresh)) begin
                do_start = 1'b1;
                pick_ser = 1'b1;
            end else if (bus_count_next != '0) begin
                do_start = 1'b1;
            end else if (ser_count_next != '0) begin
                do_start = 1'b1;
                pick_ser = 1'b1;
            end
        end
        if (do_start) begin
            n_busy     = 1'b1;
            n_busy_ser = pick_ser;
        end
    end

    always_comb begin
        res = '0;
        case (r_in.kind)
            tqts_pkg::KIND_ENQ_BUS: begin
                res.status = (bus_count == CW'(QUEUE_DEPTH)) ?
                             tqts_pkg::STATUS_FULL : tqts_pkg::STATUS_OK;
            end
            tqts_pkg::KIND_ENQ_SER: begin
                res.status = (ser_count == CW'(QUEUE_DEPTH)) ?
                             tqts_pkg::STATUS_FULL : tqts_pkg::STATUS_OK;
            end
            tqts_pkg::KIND_CPL_BUS: begin
                if (spurious) begin
                    res.status = tqts_pkg::STATUS_SPURIOUS;
                end else if (bus_cur.xfer_type == tqts_pkg::XFER_WRITE) begin
                    res.release_valid    = 1'b1;
                    res.release_buf_addr = bus_cur.buf_addr;
                end
            end
            default: begin
                if (spurious) begin
                    res.status = tqts_pkg::STATUS_SPURIOUS;
                end else begin
                    res.release_valid    = 1'b1;
                    res.release_buf_addr = ser_cur.buf_addr;
                end
            end
        endcase
        if (do_start) begin
            res.start_valid = 1'b1;
            if (pick_ser) begin
                res.start_is_serial = 1'b1;
                res.start_port      = ser_new.port;
                res.start_length    = ser_new.length;
                res.start_buf_addr  = ser_new.buf_addr;
            end else begin
                res.start_port      = bus_new.port;
                res.start_dev_addr  = bus_new.dev_addr;
                res.start_reg_addr  = bus_new.reg_addr;
                res.start_type      = bus_new.xfer_type;
                res.start_length    = bus_new.length;
                res.start_buf_addr  = bus_new.buf_addr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b0;
            r_busy_ser <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            if (fire) begin
                r_busy     <= n_busy;
                r_busy_ser <= n_busy_ser;
            end
            if (fire) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out       = r_out;

`ifndef NO_ASSERTIONS
    // The entry in flight always sits at the head of its own queue.
    a_busy_has_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_busy_ser ? (ser_count != '0) : (bus_count != '0)))
        else $error("engine busy on an empty queue");

    // A start waiting on the result port leaves the engine busy.
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.start_valid) |-> r_busy)
        else $error("start reported while engine idle");

    // A buffer is released only for an honored completion.
    a_release_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.release_valid) |-> (o_out.status == tqts_pkg::STATUS_OK))
        else $error("release with error status");
`endif

endmodule

`default_nettype wire

>>> tb/sv/tb_two_queue_transfer_scheduler.sv
module tb_two_queue_transfer_scheduler;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int QDEPTH = tqts_pkg::DEFAULT_QUEUE_DEPTH;
    localparam int TW     = tqts_pkg::THRESH_W;

    // Clock, reset and the three channels of the scheduler.
    logic                 i_clk;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    logic                 o_in_ready;
    tqts_pkg::t_in_item   i_in        = '0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    tqts_pkg::t_out_item  o_out;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [TW-1:0]        i_cfg_data  = '0;

    two_queue_transfer_scheduler DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    // One row of the directed table. Where the reaction is obvious from the
    // request alone it is typed in and checked as written; otherwise the
    // scheduler mirror below supplies it.
    typedef struct {
        tqts_pkg::t_in_item  req;
        bit                  typed;
        tqts_pkg::t_out_item react;
    } t_stim_row;

    // Mirror of the scheduler: both descriptor rings, their read pointers and
    // fill counts, the engine state and the serial priority threshold.
    tqts_pkg::t_bus_desc bus_ring [QDEPTH];
    tqts_pkg::t_ser_desc ser_ring [QDEPTH];
    int unsigned         bus_rd, bus_fill, ser_rd, ser_fill;
    bit                  engine_on, engine_serial;
    logic [TW-1:0]       prio_threshold = tqts_pkg::THRESH_RESET;

    // Reactions still owed by the scheduler, oldest first.
    tqts_pkg::t_out_item awaited_reactions [$];
    int        mismatches     = 0;
    int        send_idle_pct  = 0;
    int        recv_stall_pct = 0;
    t_stim_row directed_rows [$];

    // Applies one request to the mirror and returns the reaction it causes.
    function automatic tqts_pkg::t_out_item schedule_event(tqts_pkg::t_in_item req);
        tqts_pkg::t_out_item r;
        logic [1:0]  ty;
        int unsigned slot;
        bit          to_serial;
        bit          pick_serial;
        r = '0;
        r.status = tqts_pkg::STATUS_OK;
        // A bus type of three means nothing and is kept as a plain read.
        ty = (req.xfer_type == tqts_pkg::XFER_UNUSED) ? tqts_pkg::XFER_READ : req.xfer_type;
        case (req.kind)
            tqts_pkg::KIND_ENQ_BUS: begin
                if (bus_fill >= QDEPTH) begin
                    r.status = tqts_pkg::STATUS_FULL;
                end else begin
                    slot = (bus_rd + bus_fill) % QDEPTH;
                    bus_ring[slot].port      = req.port;
                    bus_ring[slot].dev_addr  = req.dev_addr;
                    bus_ring[slot].reg_addr  = req.reg_addr;
                    bus_ring[slot].xfer_type = ty;
                    bus_ring[slot].length    = req.length;
                    bus_ring[slot].buf_addr  = req.buf_addr;
                    bus_fill++;
                end
            end
            tqts_pkg::KIND_ENQ_SER: begin
                if (ser_fill >= QDEPTH) begin
                    r.status = tqts_pkg::STATUS_FULL;
                end else begin
                    slot = (ser_rd + ser_fill) % QDEPTH;
                    ser_ring[slot].port     = req.port;
                    ser_ring[slot].length   = req.length;
                    ser_ring[slot].buf_addr = req.buf_addr;
                    ser_fill++;
                end
            end
            default: begin
                // A completion only counts for the queue whose entry is in flight.
                to_serial = (req.kind == tqts_pkg::KIND_CPL_SER);
                if (!engine_on || engine_serial != to_serial) begin
                    r.status = tqts_pkg::STATUS_SPURIOUS;
                end else if (to_serial) begin
                    r.release_valid    = 1'b1;
                    r.release_buf_addr = ser_ring[ser_rd].buf_addr;
                    ser_rd = (ser_rd + 1) % QDEPTH;
                    ser_fill--;
                    engine_on = 1'b0;
                end else begin
                    // Only a bus write hands its buffer back.
                    if (bus_ring[bus_rd].xfer_type == tqts_pkg::XFER_WRITE) begin
                        r.release_valid    = 1'b1;
                        r.release_buf_addr = bus_ring[bus_rd].buf_addr;
                    end
                    bus_rd = (bus_rd + 1) % QDEPTH;
                    bus_fill--;
                    engine_on = 1'b0;
                end
            end
        endcase

        // Arbitration: a serial backlog above the threshold first, then the
        // bus queue, then whatever serial work remains.
        if (!engine_on && (bus_fill != 0 || ser_fill != 0)) begin
            if (ser_fill > prio_threshold)
                pick_serial = 1'b1;
            else
                pick_serial = (bus_fill == 0);
            engine_on       = 1'b1;
            engine_serial   = pick_serial;
            r.start_valid   = 1'b1;
            r.start_is_serial = pick_serial;
            if (pick_serial) begin
                r.start_port     = ser_ring[ser_rd].port;
                r.start_length   = ser_ring[ser_rd].length;
                r.start_buf_addr = ser_ring[ser_rd].buf_addr;
            end else begin
                r.start_port     = bus_ring[bus_rd].port;
                r.start_dev_addr = bus_ring[bus_rd].dev_addr;
                r.start_reg_addr = bus_ring[bus_rd].reg_addr;
                r.start_type     = bus_ring[bus_rd].xfer_type;
                r.start_length   = bus_ring[bus_rd].length;
                r.start_buf_addr = bus_ring[bus_rd].buf_addr;
            end
        end
        return r;
    endfunction

    function automatic tqts_pkg::t_out_item mk_react(bit sv, bit ser, logic [2:0] port,
                                                     logic [6:0] dev, logic [7:0] ra,
                                                     logic [1:0] ty, logic [15:0] len,
                                                     logic [31:0] addr, bit rv,
                                                     logic [31:0] raddr,
                                                     tqts_pkg::t_status st);
        tqts_pkg::t_out_item r;
        r.start_valid      = sv;
        r.start_is_serial  = ser;
        r.start_port       = port;
        r.start_dev_addr   = dev;
        r.start_reg_addr   = ra;
        r.start_type       = ty;
        r.start_length     = len;
        r.start_buf_addr   = addr;
        r.release_valid    = rv;
        r.release_buf_addr = raddr;
        r.status           = st;
        return r;
    endfunction

    function automatic t_stim_row mk_row(tqts_pkg::t_kind k, logic [2:0] port,
                                         logic [6:0] dev, logic [7:0] ra,
                                         logic [1:0] ty, logic [15:0] len,
                                         logic [31:0] addr, bit typed,
                                         tqts_pkg::t_out_item react);
        t_stim_row row;
        row.req.kind      = k;
        row.req.port      = port;
        row.req.dev_addr  = dev;
        row.req.reg_addr  = ra;
        row.req.xfer_type = ty;
        row.req.length    = len;
        row.req.buf_addr  = addr;
        row.typed         = typed;
        row.react         = react;
        return row;
    endfunction

    // Random request. Most completions name the queue that is really in
    // flight so the rings keep moving; the rest are random noise.
    function automatic tqts_pkg::t_in_item random_request(int enq_pct, int ser_pct);
        tqts_pkg::t_in_item req;
        if ($urandom_range(99) < enq_pct)
            req.kind = ($urandom_range(99) < ser_pct) ? tqts_pkg::KIND_ENQ_SER
                                                      : tqts_pkg::KIND_ENQ_BUS;
        else if (engine_on && $urandom_range(99) < 85)
            req.kind = engine_serial ? tqts_pkg::KIND_CPL_SER : tqts_pkg::KIND_CPL_BUS;
        else
            req.kind = tqts_pkg::t_kind'($urandom_range(3));
        req.port      = 3'($urandom);
        req.dev_addr  = 7'($urandom);
        req.reg_addr  = 8'($urandom);
        req.xfer_type = 2'($urandom);
        req.length    = 16'($urandom);
        req.buf_addr  = $urandom;
        return req;
    endfunction

    // Presents one request, holding it steady until the scheduler takes it,
    // then records the reaction it owes.
    task automatic send_request(input tqts_pkg::t_in_item req, input bit typed,
                                input tqts_pkg::t_out_item react);
        tqts_pkg::t_out_item mirrored;
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in       <= req;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        mirrored = schedule_event(req);
        awaited_reactions = {awaited_reactions, (typed ? react : mirrored)};
    endtask

    // Lets every owed reaction arrive and then lets the two-stage pipeline
    // settle, so the threshold can be written while idle.
    task automatic wait_drained();
        while (awaited_reactions.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_threshold(input logic [TW-1:0] value);
        i_cfg_data  <= value;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid    <= 1'b0;
        prio_threshold  = value;
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $display("%0t ns: %s mismatch, expected %h, actual %h",
                     $time, name, want, got);
            mismatches++;
        end
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // The result side backs up at random while a stall phase is active.
    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Each reaction taken from the scheduler is compared against the oldest
    // one owed. The values read here are those from before the edge.
    always @(posedge i_clk) begin
        tqts_pkg::t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (awaited_reactions.size() == 0) begin
                $display("%0t ns: reaction with none outstanding, expected none, actual %h",
                         $time, o_out);
                mismatches++;
            end else begin
                want = awaited_reactions[0];
                awaited_reactions.delete(0);
                check_field("start_valid",      want.start_valid,      o_out.start_valid);
                check_field("start_is_serial",  want.start_is_serial,  o_out.start_is_serial);
                check_field("start_port",       want.start_port,       o_out.start_port);
                check_field("start_dev_addr",   want.start_dev_addr,   o_out.start_dev_addr);
                check_field("start_reg_addr",   want.start_reg_addr,   o_out.start_reg_addr);
                check_field("start_type",       want.start_type,       o_out.start_type);
                check_field("start_length",     want.start_length,     o_out.start_length);
                check_field("start_buf_addr",   want.start_buf_addr,   o_out.start_buf_addr);
                check_field("release_valid",    want.release_valid,    o_out.release_valid);
                check_field("release_buf_addr", want.release_buf_addr, o_out.release_buf_addr);
                check_field("status",           want.status,           o_out.status);
            end
        end
    end

    // Hard stop in case the scheduler hangs; a correct run needs well under
    // a tenth of this.
    initial begin
        #2_000_000;
        $display("tb_two_queue_transfer_scheduler failed");
        $finish;
    end

    initial begin
        int       phase_thresh [8] = '{16, 0, 1, 15, 3, 16, 0, 8};
        int       enq_choices  [4] = '{20, 50, 75, 100};
        int       ser_choices  [4] = '{0, 30, 70, 100};
        int       enq_pct, ser_pct;
        tqts_pkg::t_out_item quiet;
        tqts_pkg::t_out_item spur;

        quiet = mk_react(1'b0, 1'b0, 3'd0, 7'd0, 8'd0, tqts_pkg::XFER_READ, 16'd0,
                         32'd0, 1'b0, 32'd0, tqts_pkg::STATUS_OK);
        spur  = mk_react(1'b0, 1'b0, 3'd0, 7'd0, 8'd0, tqts_pkg::XFER_READ, 16'd0,
                         32'd0, 1'b0, 32'd0, tqts_pkg::STATUS_SPURIOUS);

        // Directed part, run at the reset threshold of five with no idling.
        // Spurious completions while idle, a bus write with every field at its
        // maximum, a completion for the wrong queue, a serial request with the
        // bus-only fields set, a bus request of the meaningless type three,
        // release rules for read, write and write-then-read, and finally a
        // serial backlog of six that overtakes a waiting bus transfer.
        directed_rows = '{
            mk_row(tqts_pkg::KIND_CPL_BUS, 3'd0, 7'd0, 8'd0, tqts_pkg::XFER_READ, 16'd0,
                   32'd0, 1'b1, spur),
            mk_row(tqts_pkg::KIND_CPL_SER, 3'd0, 7'd0, 8'd0, tqts_pkg::XFER_READ, 16'd0,
                   32'd0, 1'b1, spur),
            mk_row(tqts_pkg::KIND_ENQ_BUS, 3'd7, 7'd127, 8'd255, tqts_pkg::XFER_WRITE,
                   16'hFFFF, 32'hFFFF_FFFF, 1'b1,
                   mk_react(1'b1, 1'b0, 3'd7, 7'd127, 8'd255, tqts_pkg::XFER_WRITE,
                            16'hFFFF, 32'hFFFF_FFFF, 1'b0, 32'd0, tqts_pkg::STATUS_OK)),
            mk_row(tqts_pkg::KIND_CPL_SER, 3'd0, 7'd0, 8'd0, tqts_pkg::XFER_READ, 16'd0,
                   32'd0, 1'b1, spur),
            mk_row(tqts_pkg::KIND_ENQ_SER, 3'd0, 7'd127, 8'd255, tqts_pkg::XFER_UNUSED,
                   16'd0, 32'd0, 1'b1, quiet),
            mk_row(tqts_pkg::KIND_CPL_BUS, 3'd0, 7'd0, 8'd0, tqts_pkg::XFER_READ, 16'd0,
                   32'd0, 1'b1,
                   mk_react(1'b1, 1'b1, 3'd0, 7'd0, 8'd0, tqts_pkg::XFER_READ, 16'd0,
                            32'd0, 1'b1, 32'hFFFF_FFFF, tqts_pkg::STATUS_OK)),
            mk_row(tqts_pkg::KIND_ENQ_BUS, 3'd0, 7'd0, 8'd0, tqts_pkg::XFER_UNUSED, 16'd0,
                   32'd0, 1'b1, quiet),
            mk_row(tqts_pkg::KIND_ENQ_BUS, 3'd5, 7'h55, 8'hAA, tqts_pkg::XFER_WRITE_READ,
                   16'h1234, 32'h89AB_CDEF, 1'b0, quiet),
            mk_row(tqts_pkg::KIND_CPL_SER, 3'd0, 7'd0, 8'd0, tqts_pkg::XFER_READ, 16'd0,
                   32'd0, 1'b0, quiet),
            mk_row(tqts_pkg::KIND_CPL_BUS, 3'd0, 7'd0, 8'd0, tqts_pkg::XFER_READ, 16'd0,
                   32'd0, 1'b0, quiet),
            mk_row(tqts_pkg::KIND_CPL_BUS, 3'd0, 7'd0, 8'd0, tqts_pkg::XFER_READ, 16'd0,
                   32'd0, 1'b0, quiet),
            mk_row(tqts_pkg::KIND_CPL_BUS, 3'd0, 7'd0, 8'd0, tqts_pkg::XFER_READ, 16'd0,
                   32'd0, 1'b0, quiet),
            mk_row(tqts_pkg::KIND_ENQ_BUS, 3'd2, 7'h11, 8'h22, tqts_pkg::XFER_WRITE,
                   16'h0010, 32'h0000_1000, 1'b0, quiet),
            mk_row(tqts_pkg::KIND_ENQ_SER, 3'd1, 7'd0, 8'd0, tqts_pkg::XFER_READ, 16'd1,
                   32'h2001, 1'b0, quiet),
            mk_row(tqts_pkg::KIND_ENQ_SER, 3'd2, 7'd0, 8'd0, tqts_pkg::XFER_READ, 16'd2,
                   32'h2002, 1'b0, quiet),
            mk_row(tqts_pkg::KIND_ENQ_SER, 3'd3, 7'd0, 8'd0, tqts_pkg::XFER_READ, 16'd3,
                   32'h2003, 1'b0, quiet),
            mk_row(tqts_pkg::KIND_ENQ_SER, 3'd4, 7'd0, 8'd0, tqts_pkg::XFER_READ, 16'd4,
                   32'h2004, 1'b0, quiet),
            mk_row(tqts_pkg::KIND_ENQ_SER, 3'd5, 7'd0, 8'd0, tqts_pkg::XFER_READ, 16'd5,
                   32'h2005, 1'b0, quiet),
            mk_row(tqts_pkg::KIND_ENQ_SER, 3'd6, 7'd0, 8'd0, tqts_pkg::XFER_READ, 16'd6,
                   32'h2006, 1'b0, quiet),
            mk_row(tqts_pkg::KIND_ENQ_BUS, 3'd3, 7'h7F, 8'h01, tqts_pkg::XFER_READ,
                   16'h0020, 32'h0000_3000, 1'b0, quiet),
            mk_row(tqts_pkg::KIND_CPL_BUS, 3'd0, 7'd0, 8'd0, tqts_pkg::XFER_READ, 16'd0,
                   32'd0, 1'b0, quiet),
            mk_row(tqts_pkg::KIND_CPL_SER, 3'd0, 7'd0, 8'd0, tqts_pkg::XFER_READ, 16'd0,
                   32'd0, 1'b0, quiet)
        };

        // Synchronous reset, held at the start and never repeated.
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[i])
            send_request(directed_rows[i].req, directed_rows[i].typed,
                         directed_rows[i].react);
        i_in_valid <= 1'b0;

        // Random phases. Each one rewrites the threshold while the scheduler
        // is idle, takes its own idling pattern, and varies the mix of
        // enqueues and completions in stretches so the rings both fill up to
        // the drop point and drain back out.
        foreach (phase_thresh[p]) begin
            wait_drained();
            write_threshold(TW'(phase_thresh[p]));
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 55; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 55; end
                default: begin send_idle_pct = 11; recv_stall_pct = 11; end
            endcase
            enq_pct = 50;
            ser_pct = 50;
            for (int n = 0; n < 85; n++) begin
                if (n % 20 == 0) begin
                    enq_pct = enq_choices[$urandom_range(3)];
                    ser_pct = ser_choices[$urandom_range(3)];
                end
                send_request(random_request(enq_pct, ser_pct), 1'b0, quiet);
            end
            i_in_valid <= 1'b0;
        end

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        wait_drained();
        repeat (10) @(posedge i_clk);
        if (mismatches == 0)
            $display("tb_two_queue_transfer_scheduler passed");
        else
            $display("tb_two_queue_transfer_scheduler failed");
        $finish;
    end

endmodule
